### src/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, disabled while the active-low reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion that is also checked during reset
`define ASSERT_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/rbt_pkg.sv
// Package for random_bits_to_trits: types, sizes and arithmetic helpers.
// No dependencies; used by rbt_lane, rbt_merge and the top level.
package rbt_pkg;

    localparam int unsigned WORD_W        = 64;  // random word width
    localparam int unsigned DIGITS        = 8;   // base-81 digits per word
    localparam int unsigned DIG_W         = 7;   // one digit holds 0..80
    localparam int unsigned PROD_W        = WORD_W + DIG_W;  // word times 81
    localparam int unsigned TRITS_PER_DIG = 4;   // 81 = 3^4
    localparam int unsigned TRIT_W        = 2;
    localparam int unsigned DATA_W        = 2 * WORD_W;

    // Thresholds for peeling off base-3 digits of a value below 81
    localparam logic [DIG_W-1:0] P27 = 7'd27;
    localparam logic [DIG_W-1:0] P27X2 = 7'd54;
    localparam logic [DIG_W-1:0] P9 = 7'd9;
    localparam logic [DIG_W-1:0] P9X2 = 7'd18;
    localparam logic [DIG_W-1:0] P3 = 7'd3;
    localparam logic [DIG_W-1:0] P3X2 = 7'd6;

    localparam logic [TRIT_W-1:0] TRIT_ZERO = 2'd0;
    localparam logic [TRIT_W-1:0] TRIT_ONE  = 2'd1;
    localparam logic [TRIT_W-1:0] TRIT_TWO  = 2'd2;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [DIGITS-1:0][DIG_W-1:0] t_dig_vec;   // index = step number
    typedef logic [TRITS_PER_DIG*TRIT_W-1:0] t_dig_trits;

    // Output planes; plus in the low half of the stream data
    typedef struct packed {
        logic [WORD_W-1:0] both;
        logic [WORD_W-1:0] plus;
    } t_planes;

    // x * 81 as x*64 + x*16 + x
    function automatic logic [PROD_W-1:0] f_mul81(input t_word x);
        return {1'b0, x, 6'b0} + {3'b0, x, 4'b0} + {7'b0, x};
    endfunction

    // One base-3 step: which multiple of p the value holds, and what is left
    function automatic logic [TRIT_W+DIG_W-1:0] f_step3(input logic [DIG_W-1:0] r,
                                                        input logic [DIG_W-1:0] p,
                                                        input logic [DIG_W-1:0] p2);
        logic [TRIT_W+DIG_W-1:0] res;
        if (r >= p2) begin
            res = {TRIT_TWO, r - p2};
        end else if (r >= p) begin
            res = {TRIT_ONE, r - p};
        end else begin
            res = {TRIT_ZERO, r};
        end
        return res;
    endfunction

    // Digit 0..80 to four trits, least trit in bits 1:0
    function automatic t_dig_trits f_trits(input logic [DIG_W-1:0] d);
        logic [TRIT_W+DIG_W-1:0] s3;
        logic [TRIT_W+DIG_W-1:0] s2;
        logic [TRIT_W+DIG_W-1:0] s1;
        s3 = f_step3(d, P27, P27X2);
        s2 = f_step3(s3[DIG_W-1:0], P9, P9X2);
        s1 = f_step3(s2[DIG_W-1:0], P3, P3X2);
        return {s3[TRIT_W+DIG_W-1:DIG_W], s2[TRIT_W+DIG_W-1:DIG_W],
                s1[TRIT_W+DIG_W-1:DIG_W], s1[TRIT_W-1:0]};
    endfunction

endpackage

### src/rbt_lane.sv
// One lane: eight-stage pipeline that peels base-81 digits off a 64-bit word.
// Depends on rbt_pkg.
module rbt_lane (
    input  logic                           i_clk,
    input  logic [rbt_pkg::DIGITS-1:0]     i_load,    // per-stage load enable
    input  rbt_pkg::t_word                 i_word,
    output rbt_pkg::t_dig_vec              o_digits
);

    rbt_pkg::t_word    r_rem [rbt_pkg::DIGITS-1];
    rbt_pkg::t_dig_vec r_dig [rbt_pkg::DIGITS];

    // Stage s multiplies by 81: high bits are digit s, low 64 bits go on
    for (genvar s = 0; s < rbt_pkg::DIGITS; s++) begin : g_stage
        rbt_pkg::t_word                w_src;
        rbt_pkg::t_dig_vec             w_prev;
        rbt_pkg::t_dig_vec             n_dig;
        logic [rbt_pkg::PROD_W-1:0]    w_prod;

        if (s == 0) begin : g_first
            assign w_src  = i_word;
            assign w_prev = '0;
        end else begin : g_next
            assign w_src  = r_rem[s-1];
            assign w_prev = r_dig[s-1];
        end

        assign w_prod = rbt_pkg::f_mul81(w_src);

        always_comb begin
            n_dig    = w_prev;
            n_dig[s] = w_prod[rbt_pkg::PROD_W-1:rbt_pkg::WORD_W];
        end

        always_ff @(posedge i_clk) begin
            if (i_load[s]) begin
                r_dig[s] <= n_dig;
            end
        end

        // Last stage has no remainder to keep
        if (s < rbt_pkg::DIGITS - 1) begin : g_rem
            always_ff @(posedge i_clk) begin
                if (i_load[s]) begin
                    r_rem[s] <= w_prod[rbt_pkg::WORD_W-1:0];
                end
            end
        end
    end

    assign o_digits = r_dig[rbt_pkg::DIGITS-1];

endmodule

### src/rbt_merge.sv
// Merge stage: converts both lanes' digits to trits and interleaves them
// into the plus and both bit planes. Depends on rbt_pkg.
module rbt_merge (
    input  rbt_pkg::t_dig_vec i_dig_a,   // first word, even positions
    input  rbt_pkg::t_dig_vec i_dig_b,   // second word, odd positions
    output rbt_pkg::t_planes  o_planes
);

    // Digit s lands in byte DIGITS-1-s; trit i of that byte is trit 4*byte+i
    always_comb begin
        rbt_pkg::t_dig_trits ta;
        rbt_pkg::t_dig_trits tb;
        o_planes = '0;
        for (int s = 0; s < rbt_pkg::DIGITS; s++) begin
            ta = rbt_pkg::f_trits(i_dig_a[s]);
            tb = rbt_pkg::f_trits(i_dig_b[s]);
            for (int i = 0; i < rbt_pkg::TRITS_PER_DIG; i++) begin
                o_planes.plus[2*(4*(rbt_pkg::DIGITS-1-s)+i)] =
                    (ta[2*i +: 2] != rbt_pkg::TRIT_ZERO);
                o_planes.both[2*(4*(rbt_pkg::DIGITS-1-s)+i)] =
                    (ta[2*i +: 2] == rbt_pkg::TRIT_TWO);
                o_planes.plus[2*(4*(rbt_pkg::DIGITS-1-s)+i)+1] =
                    (tb[2*i +: 2] != rbt_pkg::TRIT_ZERO);
                o_planes.both[2*(4*(rbt_pkg::DIGITS-1-s)+i)+1] =
                    (tb[2*i +: 2] == rbt_pkg::TRIT_TWO);
            end
        end
    end

endmodule

### src/random_bits_to_trits.sv
// Pipeline: 8 multiply-by-81 stages per lane, the last one feeding the merge
// stage into the output register.
// Throughput: one word pair per cycle; each lane's stage chain is fully
// pipelined and stalls only where a stage is full and cannot move on.
// Reset: synchronous, active low; clears all stage valid bits and the output valid.
// Depends on rbt_pkg, rbt_lane, rbt_merge.
module random_bits_to_trits (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [rbt_pkg::DATA_W-1:0]   i_s_tdata,   // [63:0] first_word, [127:64] second_word
    input  logic                         i_s_tlast,   // last_in
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [rbt_pkg::DATA_W-1:0]   o_m_tdata,   // [63:0] plus_plane, [127:64] both_plane
    output logic                         o_m_tlast    // last_out
);

    localparam int unsigned D = rbt_pkg::DIGITS;

    logic [D-1:0]      r_v;
    logic [D-1:0]      n_v;
    logic [D-1:0]      r_last;
    logic [D:0]        w_rdy;
    logic              r_ov;
    logic              r_olast;
    rbt_pkg::t_planes  r_planes;
    rbt_pkg::t_planes  w_planes;
    rbt_pkg::t_dig_vec w_dig_a;
    rbt_pkg::t_dig_vec w_dig_b;

    // A stage may load when it is empty or its contents move on
    always_comb begin
        w_rdy[D] = !r_ov || i_m_tready;
        for (int s = D - 1; s >= 0; s--) begin
            w_rdy[s] = !r_v[s] || w_rdy[s+1];
        end
    end

    assign o_s_tready = w_rdy[0];

    // Stage valid bits and last flags
    always_comb begin
        n_v = r_v;
        if (w_rdy[0]) begin
            n_v[0] = i_s_tvalid;
        end
        for (int s = 1; s < D; s++) begin
            if (w_rdy[s]) begin
                n_v[s] = r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_last[0] <= i_s_tlast;
        end
        for (int s = 1; s < D; s++) begin
            if (w_rdy[s]) begin
                r_last[s] <= r_last[s-1];
            end
        end
    end

    // Two lanes, one per word
    rbt_lane u_lane_a (
        .i_clk    (i_clk),
        .i_load   (w_rdy[D-1:0]),
        .i_word   (i_s_tdata[rbt_pkg::WORD_W-1:0]),
        .o_digits (w_dig_a)
    );

    rbt_lane u_lane_b (
        .i_clk    (i_clk),
        .i_load   (w_rdy[D-1:0]),
        .i_word   (i_s_tdata[rbt_pkg::DATA_W-1:rbt_pkg::WORD_W]),
        .o_digits (w_dig_b)
    );

    rbt_merge u_merge (
        .i_dig_a  (w_dig_a),
        .i_dig_b  (w_dig_b),
        .o_planes (w_planes)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_rdy[D]) begin
            r_ov <= r_v[D-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[D] && r_v[D-1]) begin
            r_planes <= w_planes;
            r_olast  <= r_last[D-1];
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_planes;
    assign o_m_tlast  = r_olast;

endmodule

### src/rbt_checker.sv
// Port-level checker for random_bits_to_trits, bound to the top level.
// Depends on assert_macros.svh and rbt_pkg.
`include "assert_macros.svh"

module rbt_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_s_tready,
    input logic                         o_m_tvalid,
    input logic                         i_m_tready,
    input logic [rbt_pkg::DATA_W-1:0]   o_m_tdata,
    input logic                         o_m_tlast
);

    // A stalled output transaction keeps valid and payload
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output valid dropped while stalled")
    `ASSERT_CLK(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "output payload changed while stalled")

    // A trit equal to 2 is also nonzero
    `ASSERT_CLK(a_planes, i_clk, i_rst_n, o_m_tvalid |-> ((o_m_tdata[rbt_pkg::DATA_W-1:rbt_pkg::WORD_W] & ~o_m_tdata[rbt_pkg::WORD_W-1:0]) == '0), "both plane set where plus plane is clear")

    // Empty output register means the pipeline can take input
    `ASSERT_CLK(a_ready, i_clk, i_rst_n, !o_m_tvalid |-> o_s_tready, "input not ready while output register is empty")

    // Reset empties the output
    `ASSERT_NR(a_reset, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid after reset")

endmodule

bind random_bits_to_trits rbt_checker u_rbt_checker (.*);

### test/tb.sv
// Testbench for random_bits_to_trits: random word pairs in, bit-sliced trit planes out.
// Predicts each result in-bench and checks it in order; depends on rbt_pkg and the RTL.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned DRAIN_CYCLES = 20;   // margin over the pipeline latency
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct {
        rbt_pkg::t_word plus;
        rbt_pkg::t_word both;
        logic           last;
    } t_trit_planes;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [rbt_pkg::DATA_W-1:0]  s_tdata;    // [63:0] first_word, [127:64] second_word
    logic                        s_tlast;    // last_in
    logic                        m_tvalid;
    logic                        m_tready;
    logic [rbt_pkg::DATA_W-1:0]  m_tdata;    // [63:0] plus_plane, [127:64] both_plane
    logic                        m_tlast;    // last_out

    t_trit_planes expected_planes[$];
    int unsigned  src_idle_pct;
    int unsigned  sink_stall_pct;
    int unsigned  holdoff_left;
    int unsigned  pairs_sent;
    int unsigned  planes_checked;
    int unsigned  mismatches;
    int unsigned  unexpected;
    int unsigned  input_stall_cycles;
    int unsigned  cycle_count;

    random_bits_to_trits uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    // Clock, 20 ns period
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // Word as a fraction of 2^64: eight base-81 digits, then four trits per digit.
    // The first digit lands in the top byte; trit k sits at bits 2k+1:2k.
    function automatic rbt_pkg::t_word word_trits(input rbt_pkg::t_word x);
        logic [2*rbt_pkg::WORD_W-1:0] prod;
        rbt_pkg::t_word               frac;
        rbt_pkg::t_word               trits;
        int unsigned                  digit;
        frac  = x;
        trits = '0;
        for (int s = 0; s < 8; s++) begin
            prod  = {{rbt_pkg::WORD_W{1'b0}}, frac} * 128'd81;
            digit = int'(prod[2*rbt_pkg::WORD_W-1:rbt_pkg::WORD_W]);
            frac  = prod[rbt_pkg::WORD_W-1:0];
            for (int i = 0; i < 4; i++) begin
                trits[8*(7-s) + 2*i +: 2] = 2'(digit % 3);
                digit = digit / 3;
            end
        end
        return trits;
    endfunction

    // First word feeds even plane bits, second word the odd ones
    function automatic t_trit_planes predict_planes(input rbt_pkg::t_word first_w,
                                                    input rbt_pkg::t_word second_w,
                                                    input logic last);
        t_trit_planes   res;
        rbt_pkg::t_word even_trits;
        rbt_pkg::t_word odd_trits;
        even_trits = word_trits(first_w);
        odd_trits  = word_trits(second_w);
        res.plus = '0;
        res.both = '0;
        res.last = last;
        for (int k = 0; k < 32; k++) begin
            res.plus[2*k]   = (even_trits[2*k +: 2] != 2'd0);
            res.both[2*k]   = (even_trits[2*k +: 2] == 2'd2);
            res.plus[2*k+1] = (odd_trits[2*k +: 2] != 2'd0);
            res.both[2*k+1] = (odd_trits[2*k +: 2] == 2'd2);
        end
        return res;
    endfunction

    // Mostly uniform words, with some sparse and near-full ones mixed in
    function automatic rbt_pkg::t_word rand_word();
        rbt_pkg::t_word w;
        case ($urandom_range(9))
            0: w = rbt_pkg::t_word'($urandom_range(255));
            1: w = ~rbt_pkg::t_word'($urandom_range(255));
            2: w = {$urandom, 32'h0};
            3: w = {32'h0, $urandom};
            default: w = {$urandom, $urandom};
        endcase
        return w;
    endfunction

    // Offer one word pair, with random idle cycles first; returns once accepted
    task automatic send_pair(input rbt_pkg::t_word first_w, input rbt_pkg::t_word second_w,
                             input logic last);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {second_w, first_w};
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        expected_planes.push_back(predict_planes(first_w, second_w, last));
        pairs_sent++;
    endtask

    // One vector of random pairs, last flag on the final one
    task automatic send_vector(input int unsigned n_pairs);
        for (int unsigned i = 0; i < n_pairs; i++)
            send_pair(rand_word(), rand_word(), i == n_pairs - 1);
    endtask

    task automatic test_directed();
        send_pair('0, '0, 1'b0);
        send_pair('1, '1, 1'b1);
        send_pair('0, '1, 1'b0);
        send_pair('1, '0, 1'b1);
        send_pair(64'h1, 64'h8000_0000_0000_0000, 1'b0);
        send_pair(64'h8000_0000_0000_0000, 64'h1, 1'b0);
        send_pair(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        send_pair(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 1'b0);
        // Digit boundaries: 2^64 * k / 81 for a few k, and one below
        send_pair(64'h0329_161F_9ADD_3C0D, 64'h0329_161F_9ADD_3C0C, 1'b0);
        send_pair(64'hFCD6_E9E0_6522_C3F2, 64'hFCD6_E9E0_6522_C3F3, 1'b1);
        send_pair(64'h5555_5555_5555_5556, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0);
        send_pair(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF, 1'b0);
        send_pair(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210, 1'b1);
        send_pair(64'h7FFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
    endtask

    task automatic test_random_vectors(input int unsigned n_pairs);
        int unsigned left;
        int unsigned len;
        left = n_pairs;
        while (left > 0) begin
            len = $urandom_range(8, 1);
            if (len > left) len = left;
            send_vector(len);
            left -= len;
        end
    endtask

    // Full rate on both sides: back-to-back transactions through the pipe
    task automatic test_full_rate();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        test_random_vectors(220);
        src_idle_pct   = 37;
        sink_stall_pct = 37;
    endtask

    // Sink holds off while the source keeps offering, so the pipe fills and stalls
    task automatic test_backpressure();
        src_idle_pct = 0;
        holdoff_left = 150;
        test_random_vectors(60);
        src_idle_pct = 37;
    endtask

    // Sink ready, with random stalls and the hold-off window
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_left > 0) begin
                m_tready <= 1'b0;
                holdoff_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Output checker: each transaction against the oldest prediction
    always @(posedge i_clk) begin
        t_trit_planes want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_planes.size() == 0) begin
                unexpected++;
                if (mismatches + unexpected <= MAX_REPORTS)
                    $display("unexpected result: plus=%h both=%h last=%b",
                             m_tdata[rbt_pkg::WORD_W-1:0],
                             m_tdata[rbt_pkg::DATA_W-1:rbt_pkg::WORD_W], m_tlast);
            end else begin
                want = expected_planes.pop_front();
                planes_checked++;
                if (m_tdata[rbt_pkg::WORD_W-1:0] !== want.plus ||
                    m_tdata[rbt_pkg::DATA_W-1:rbt_pkg::WORD_W] !== want.both ||
                    m_tlast !== want.last) begin
                    mismatches++;
                    if (mismatches + unexpected <= MAX_REPORTS)
                        $display({"mismatch #%0d: plus exp %h got %h, ",
                                  "both exp %h got %h, last exp %b got %b"},
                                 planes_checked, want.plus, m_tdata[rbt_pkg::WORD_W-1:0],
                                 want.both, m_tdata[rbt_pkg::DATA_W-1:rbt_pkg::WORD_W],
                                 want.last, m_tlast);
                end
            end
        end
    end

    // Input stall count and run timeout
    always @(posedge i_clk) begin
        cycle_count++;
        if (i_rst_n && s_tvalid && !s_tready)
            input_stall_cycles++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb failed");
            $finish;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tlast            = 1'b0;
        src_idle_pct       = 37;
        sink_stall_pct     = 37;
        holdoff_left       = 0;
        pairs_sent         = 0;
        planes_checked     = 0;
        mismatches         = 0;
        unexpected         = 0;
        input_stall_cycles = 0;
        cycle_count        = 0;

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_vectors(480);
        test_full_rate();
        test_backpressure();
        test_random_vectors(330);

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (expected_planes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d word pairs sent, %0d results checked, %0d input stall cycles",
                 pairs_sent, planes_checked, input_stall_cycles);
        $display("%0d mismatched and %0d unexpected results", mismatches, unexpected);
        if (mismatches == 0 && unexpected == 0 && expected_planes.size() == 0) begin
            $display("tb passed");
        end else begin
            $display("tb failed");
        end
        $finish;
    end

endmodule
